// ----- rtl/hita_pkg.sv -----
// Shared types and codes for the hierarchical I/O token admission block.
// Used by hita_cfg, hita_engine and hierarchical_io_token_admission.
package hita_pkg;

  localparam int FIELD_WIDTH = 48;
  localparam int FRAC_WIDTH  = 9;
  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic [FRAC_WIDTH-1:0] FRAC_MAX   = 9'd256;
  localparam logic [FRAC_WIDTH-1:0] FRAC_RESET = 9'd26;

  localparam longint unsigned BORROW_FLOOR_OPS   = 64'd1024;
  localparam longint unsigned BORROW_FLOOR_BYTES = 64'd4194304;

  localparam logic [2:0] OP_ACQUIRE     = 3'd0;
  localparam logic [2:0] OP_REFUND      = 3'd1;
  localparam logic [2:0] OP_EPOCH       = 3'd2;
  localparam logic [2:0] OP_LOAD_SHARED = 3'd3;
  localparam logic [2:0] OP_LOAD_POOL   = 3'd4;

  localparam logic [2:0] ST_LOCAL  = 3'd0;
  localparam logic [2:0] ST_SHARED = 3'd1;
  localparam logic [2:0] ST_GLOBAL = 3'd2;
  localparam logic [2:0] ST_DENIED = 3'd3;
  localparam logic [2:0] ST_BYPASS = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_QUOTA_ENABLE   = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BORROW_ENABLE  = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LATENCY_CRIT   = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BATCH_FRACTION = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RESERVE_OPS    = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RESERVE_BYTES  = 3'd5;

  typedef struct packed {
    logic                  quota_enable;
    logic                  borrow_enable;
    logic                  latency_critical;
    logic [FRAC_WIDTH-1:0] batch_fraction;
  } cfg_t;

endpackage

// ----- rtl/hita_cfg.sv -----
// Configuration registers of the token admission block.
// Depends on hita_pkg.
module hita_cfg #(
  parameter int TOKEN_WIDTH = 48
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [hita_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [hita_pkg::FIELD_WIDTH-1:0]      cfg_data,
  output hita_pkg::cfg_t                        cfg,
  output logic [TOKEN_WIDTH-1:0]                reserve_ops,
  output logic [TOKEN_WIDTH-1:0]                byte_reserve
);
  import hita_pkg::*;

  logic [TOKEN_WIDTH+FIELD_WIDTH-1:0] data_ext;
  logic [TOKEN_WIDTH-1:0]             data_tok;

  assign data_ext = {{TOKEN_WIDTH{1'b0}}, cfg_data};
  assign data_tok = data_ext[TOKEN_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quota_enable     <= 1'b0;
      cfg.borrow_enable    <= 1'b1;
      cfg.latency_critical <= 1'b0;
      cfg.batch_fraction   <= FRAC_RESET;
      reserve_ops          <= '0;
      byte_reserve         <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_QUOTA_ENABLE:   cfg.quota_enable     <= cfg_data[0];
        CFG_BORROW_ENABLE:  cfg.borrow_enable    <= cfg_data[0];
        CFG_LATENCY_CRIT:   cfg.latency_critical <= cfg_data[0];
        CFG_BATCH_FRACTION: cfg.batch_fraction   <= cfg_data[FRAC_WIDTH-1:0];
        CFG_RESERVE_OPS:    reserve_ops          <= data_tok;
        CFG_RESERVE_BYTES:  byte_reserve         <= data_tok;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/hita_engine.sv -----
// Token state and single-pass admission decision for one request.
// Depends on hita_pkg; configuration comes from hita_cfg.
module hita_engine #(
  parameter int TOKEN_WIDTH = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  logic [2:0]             opcode,
  input  logic [TOKEN_WIDTH-1:0] ops,
  input  logic [TOKEN_WIDTH-1:0] bytes,
  input  hita_pkg::cfg_t         cfg,
  input  logic [TOKEN_WIDTH-1:0] reserve_ops,
  input  logic [TOKEN_WIDTH-1:0] byte_reserve,
  output logic [2:0]             status,
  output logic [TOKEN_WIDTH-1:0] local_ops_next,
  output logic [TOKEN_WIDTH-1:0] local_bytes_next
);
  import hita_pkg::*;

  localparam logic [TOKEN_WIDTH-1:0] FLOOR_OPS   = TOKEN_WIDTH'(BORROW_FLOOR_OPS);
  localparam logic [TOKEN_WIDTH-1:0] FLOOR_BYTES = TOKEN_WIDTH'(BORROW_FLOOR_BYTES);

  logic [TOKEN_WIDTH-1:0] local_ops, local_bytes, quota_ops, quota_bytes;
  logic [TOKEN_WIDTH-1:0] shared_ops, shared_bytes, pool_ops, pool_bytes;
  logic [TOKEN_WIDTH-1:0] quota_ops_next, quota_bytes_next;
  logic [TOKEN_WIDTH-1:0] shared_ops_next, shared_bytes_next;
  logic [TOKEN_WIDTH-1:0] pool_ops_next, pool_bytes_next;
  logic [TOKEN_WIDTH-1:0] qb_ops, qb_bytes;

  logic [FRAC_WIDTH-1:0]  frac;
  logic                   epoch;
  logic [TOKEN_WIDTH-1:0] qsrc_ops, qsrc_bytes;

  logic                   local_ok, shared_ok, pool_ok;
  logic [TOKEN_WIDTH-1:0] need_ops, byte_short;
  logic [TOKEN_WIDTH-1:0] bs_ops, bs_bytes, pull_ops, byte_pull;
  logic [TOKEN_WIDTH-1:0] rsv_ops, rsv_bytes, cap_ops, byte_room;
  logic [TOKEN_WIDTH-1:0] bb_ops, bb_bytes, borrow_ops, byte_loan;
  logic [TOKEN_WIDTH-1:0] add_ops, add_bytes;
  logic [TOKEN_WIDTH-1:0] acq_ops, acq_bytes;

  function automatic logic [TOKEN_WIDTH-1:0] sat_add(input logic [TOKEN_WIDTH-1:0] a,
                                                     input logic [TOKEN_WIDTH-1:0] b);
    logic [TOKEN_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOKEN_WIDTH] ? {TOKEN_WIDTH{1'b1}} : s[TOKEN_WIDTH-1:0];
  endfunction

  function automatic logic [TOKEN_WIDTH-1:0] frac_mul(input logic [TOKEN_WIDTH-1:0] q,
                                                      input logic [FRAC_WIDTH-1:0] f);
    logic [TOKEN_WIDTH:0] p_hi;
    logic [16:0]          p_lo;
    logic [TOKEN_WIDTH:0] s;
    p_hi = {9'b0, q[TOKEN_WIDTH-1:8]} * {{(TOKEN_WIDTH-8){1'b0}}, f};
    p_lo = {9'b0, q[7:0]} * {8'b0, f};
    s    = p_hi + {{(TOKEN_WIDTH-8){1'b0}}, p_lo[16:8]};
    return s[TOKEN_WIDTH-1:0];
  endfunction

  assign frac       = (cfg.batch_fraction > FRAC_MAX) ? FRAC_MAX : cfg.batch_fraction;
  assign epoch      = fire && (opcode == OP_EPOCH);
  assign qsrc_ops   = epoch ? ops : quota_ops;
  assign qsrc_bytes = epoch ? bytes : quota_bytes;

  always_ff @(posedge clk) begin
    qb_ops   <= frac_mul(qsrc_ops, frac);
    qb_bytes <= frac_mul(qsrc_bytes, frac);
  end

  always_comb begin
    local_ok   = (local_ops >= ops) && (local_bytes >= bytes);
    need_ops   = (ops > local_ops) ? ops - local_ops : '0;
    byte_short = (bytes > local_bytes) ? bytes - local_bytes : '0;
    shared_ok  = (shared_ops >= need_ops) && (shared_bytes >= byte_short);

    bs_ops     = (need_ops == '0) ? '0 : ((qb_ops > need_ops) ? qb_ops : need_ops);
    bs_bytes   = (byte_short == '0) ? '0 : ((qb_bytes > byte_short) ? qb_bytes : byte_short);
    pull_ops   = (bs_ops > shared_ops) ? shared_ops : bs_ops;
    byte_pull  = (bs_bytes > shared_bytes) ? shared_bytes : bs_bytes;

    rsv_ops    = cfg.latency_critical ? '0 : reserve_ops;
    rsv_bytes  = cfg.latency_critical ? '0 : byte_reserve;
    cap_ops    = (pool_ops > rsv_ops) ? pool_ops - rsv_ops : '0;
    byte_room  = (pool_bytes > rsv_bytes) ? pool_bytes - rsv_bytes : '0;
    pool_ok    = cfg.borrow_enable && ((need_ops == '0) || (cap_ops >= need_ops)) &&
                 ((byte_short == '0) || (byte_room >= byte_short));

    bb_ops       = (need_ops == '0) ? '0 : ((bs_ops > FLOOR_OPS) ? bs_ops : FLOOR_OPS);
    bb_bytes     = (byte_short == '0) ? '0 :
                   ((bs_bytes > FLOOR_BYTES) ? bs_bytes : FLOOR_BYTES);
    borrow_ops   = (bb_ops > cap_ops) ? cap_ops : bb_ops;
    byte_loan    = (bb_bytes > byte_room) ? byte_room : bb_bytes;

    if (local_ok) begin
      add_ops   = '0;
      add_bytes = '0;
    end else if (shared_ok) begin
      add_ops   = pull_ops;
      add_bytes = byte_pull;
    end else begin
      add_ops   = borrow_ops;
      add_bytes = byte_loan;
    end
    acq_ops   = sat_add(local_ops, add_ops) - ops;
    acq_bytes = sat_add(local_bytes, add_bytes) - bytes;
  end

  always_comb begin
    status            = ST_DENIED;
    local_ops_next    = local_ops;
    local_bytes_next  = local_bytes;
    quota_ops_next    = quota_ops;
    quota_bytes_next  = quota_bytes;
    shared_ops_next   = shared_ops;
    shared_bytes_next = shared_bytes;
    pool_ops_next     = pool_ops;
    pool_bytes_next   = pool_bytes;
    case (opcode)
      OP_ACQUIRE: begin
        if (!cfg.quota_enable) begin
          status = ST_BYPASS;
        end else if (local_ok || shared_ok || pool_ok) begin
          local_ops_next   = acq_ops;
          local_bytes_next = acq_bytes;
          if (local_ok) begin
            status = ST_LOCAL;
          end else if (shared_ok) begin
            status            = ST_SHARED;
            shared_ops_next   = shared_ops - pull_ops;
            shared_bytes_next = shared_bytes - byte_pull;
          end else begin
            status          = ST_GLOBAL;
            pool_ops_next   = pool_ops - borrow_ops;
            pool_bytes_next = pool_bytes - byte_loan;
          end
        end
      end
      OP_REFUND: begin
        if (!cfg.quota_enable) begin
          status = ST_BYPASS;
        end else begin
          status           = ST_DONE;
          local_ops_next   = sat_add(local_ops, ops);
          local_bytes_next = sat_add(local_bytes, bytes);
        end
      end
      OP_EPOCH: begin
        status           = ST_DONE;
        quota_ops_next   = ops;
        quota_bytes_next = bytes;
        local_ops_next   = '0;
        local_bytes_next = '0;
      end
      OP_LOAD_SHARED: begin
        status            = ST_DONE;
        shared_ops_next   = ops;
        shared_bytes_next = bytes;
      end
      OP_LOAD_POOL: begin
        status          = ST_DONE;
        pool_ops_next   = ops;
        pool_bytes_next = bytes;
      end
      default: status = ST_DENIED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      local_ops    <= '0;
      local_bytes  <= '0;
      quota_ops    <= '0;
      quota_bytes  <= '0;
      shared_ops   <= '0;
      shared_bytes <= '0;
      pool_ops     <= '0;
      pool_bytes   <= '0;
    end else if (fire) begin
      local_ops    <= local_ops_next;
      local_bytes  <= local_bytes_next;
      quota_ops    <= quota_ops_next;
      quota_bytes  <= quota_bytes_next;
      shared_ops   <= shared_ops_next;
      shared_bytes <= shared_bytes_next;
      pool_ops     <= pool_ops_next;
      pool_bytes   <= pool_bytes_next;
    end
  end

endmodule

// ----- rtl/hierarchical_io_token_admission.sv -----
// Top level of the hierarchical I/O token admission block: stream ports,
// input register and result register. Depends on hita_pkg, hita_cfg, hita_engine.
//
// One request is taken per clock unless the input side stalls. A request transfers
// into the input register, the admission decision and all token updates happen in
// one pass from there into the result register, so a result is offered once it is
// registered there and requests may follow back to back. The token state updates as
// each result is registered, so the next request always sees it. A stalled result
// register holds the input register, and the input side stalls only when both are
// full.
module hierarchical_io_token_admission #(
  parameter int TOKEN_WIDTH = 48
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [95:0]                          s_tdata,   // op_amount, byte_amount
  input  logic [2:0]                           s_tuser,   // opcode
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [95:0]                          m_tdata,   // local_op_tokens, local_byte_tokens
  output logic [2:0]                           m_tuser,   // status
  input  logic                                 cfg_we,
  input  logic [hita_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [hita_pkg::FIELD_WIDTH-1:0]     cfg_data
);
  import hita_pkg::*;

  logic                   in_valid;
  logic [2:0]             in_opcode;
  logic [FIELD_WIDTH-1:0] in_ops, in_bytes;
  logic                   advance;

  logic [TOKEN_WIDTH+FIELD_WIDTH-1:0] ops_ext, bytes_ext;
  logic [TOKEN_WIDTH-1:0]             ops_tok, bytes_tok;

  cfg_t                   cfg;
  logic [TOKEN_WIDTH-1:0] reserve_ops, byte_reserve;
  logic [2:0]             status;
  logic [TOKEN_WIDTH-1:0] local_ops_next, local_bytes_next;
  logic [TOKEN_WIDTH+FIELD_WIDTH-1:0] lo_ext, lb_ext;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_opcode <= s_tuser;
      in_ops    <= s_tdata[47:0];
      in_bytes  <= s_tdata[95:48];
    end
  end

  assign ops_ext   = {{TOKEN_WIDTH{1'b0}}, in_ops};
  assign bytes_ext = {{TOKEN_WIDTH{1'b0}}, in_bytes};
  assign ops_tok   = ops_ext[TOKEN_WIDTH-1:0];
  assign bytes_tok = bytes_ext[TOKEN_WIDTH-1:0];

  hita_cfg #(
    .TOKEN_WIDTH(TOKEN_WIDTH)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg),
    .reserve_ops  (reserve_ops),
    .byte_reserve (byte_reserve)
  );

  hita_engine #(
    .TOKEN_WIDTH(TOKEN_WIDTH)
  ) u_engine (
    .clk             (clk),
    .rst             (rst),
    .fire            (advance),
    .opcode          (in_opcode),
    .ops             (ops_tok),
    .bytes           (bytes_tok),
    .cfg             (cfg),
    .reserve_ops     (reserve_ops),
    .byte_reserve    (byte_reserve),
    .status          (status),
    .local_ops_next  (local_ops_next),
    .local_bytes_next(local_bytes_next)
  );

  assign lo_ext = {{FIELD_WIDTH{1'b0}}, local_ops_next};
  assign lb_ext = {{FIELD_WIDTH{1'b0}}, local_bytes_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tuser <= status;
      m_tdata <= {lb_ext[FIELD_WIDTH-1:0], lo_ext[FIELD_WIDTH-1:0]};
    end
  end

endmodule
